// File: src/dags_pkg.sv
package dags_pkg;

	// Pool geometry and link encoding
	localparam int POOL_SIZE = 128;
	localparam int VID_W     = $clog2(POOL_SIZE);
	localparam int LINK_W    = VID_W + 1;
	localparam int CNT_W     = VID_W + 1;

	typedef logic [VID_W-1:0]  vid_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Top bit set marks the end of a list
	localparam link_t NONE_ID = '1;

	typedef enum logic [1:0] {
		CMD_NEW_VERTEX = 2'd0,
		CMD_NEW_EDGE   = 2'd1,
		CMD_DEL_EDGE   = 2'd2,
		CMD_DEL_VERTEX = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_BAD  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_CV_WR,
		S_CE_LINK,
		S_CE_FIX,
		S_UN_FETCH,
		S_UN_HEADS,
		S_UN_PATCH,
		S_UN_FREE,
		S_VD_SCAN,
		S_VD_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		cmd_t command;
		vid_t tail_vertex;
		vid_t head_vertex;
		vid_t edge_id;
		vid_t vertex_id;
	} item_t;

	typedef struct packed {
		vid_t    new_id;
		status_t status;
		cnt_t    vertex_count;
		cnt_t    edge_count;
		cnt_t    removed_edges;
	} result_t;

	// A link points at a slot when its top bit is clear
	function automatic logic link_ok(link_t x);
		return ~x[LINK_W-1];
	endfunction

	function automatic link_t to_link(vid_t x);
		return {1'b0, x};
	endfunction

endpackage

// File: src/dags_ram.sv
module dags_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/dags_seq.sv
module dags_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dags_pkg::item_t   item_in,
	input  logic              out_free,
	output logic              ready,
	output logic              done,
	output dags_pkg::result_t result
);

	dags_pkg::state_t state_q, state_nx;

	// Latched command
	dags_pkg::cmd_t cmd_q;
	dags_pkg::vid_t tail_q, head_q, vid_q, cur_q;

	// Pool bookkeeping
	logic [dags_pkg::POOL_SIZE-1:0] vlive_q, elive_q;
	dags_pkg::link_t fvh_q, feh_q;
	dags_pkg::cnt_t  vhm_q, ehm_q, vcnt_q, ecnt_q, removed_q;

	// Result and scratch
	dags_pkg::vid_t    new_id_q;
	dags_pkg::status_t status_q;
	logic              pop_q;
	dags_pkg::link_t   oldout_q, oldin_q;
	dags_pkg::vid_t    t_q, h_q;
	dags_pkg::link_t   n_q, p_q, dn_q, dp_q;

	// RAM ports
	logic vin_we, vout_we, et_we, eh_we, en_we, ep_we, edn_we, edp_we;
	dags_pkg::vid_t vin_wa, vout_wa, en_wa, ep_wa, edn_wa, edp_wa, e_wa;
	dags_pkg::vid_t vin_ra, vout_ra, e_ra;
	dags_pkg::link_t vin_wd, vout_wd, en_wd, ep_wd, edn_wd, edp_wd;
	dags_pkg::link_t vin_rd, vout_rd, en_rd, ep_rd, edn_rd, edp_rd;
	dags_pkg::vid_t et_wd, eh_wd, et_rd, eh_rd;

	dags_ram #(.WIDTH(dags_pkg::LINK_W), .DEPTH(dags_pkg::POOL_SIZE)) u_vin (
		.clk(clk), .we(vin_we), .waddr(vin_wa), .wdata(vin_wd), .raddr(vin_ra), .rdata(vin_rd));
	dags_ram #(.WIDTH(dags_pkg::LINK_W), .DEPTH(dags_pkg::POOL_SIZE)) u_vout (
		.clk(clk), .we(vout_we), .waddr(vout_wa), .wdata(vout_wd), .raddr(vout_ra),
		.rdata(vout_rd));
	dags_ram #(.WIDTH(dags_pkg::VID_W), .DEPTH(dags_pkg::POOL_SIZE)) u_etail (
		.clk(clk), .we(et_we), .waddr(e_wa), .wdata(et_wd), .raddr(e_ra), .rdata(et_rd));
	dags_ram #(.WIDTH(dags_pkg::VID_W), .DEPTH(dags_pkg::POOL_SIZE)) u_ehead (
		.clk(clk), .we(eh_we), .waddr(e_wa), .wdata(eh_wd), .raddr(e_ra), .rdata(eh_rd));
	dags_ram #(.WIDTH(dags_pkg::LINK_W), .DEPTH(dags_pkg::POOL_SIZE)) u_enext (
		.clk(clk), .we(en_we), .waddr(en_wa), .wdata(en_wd), .raddr(e_ra), .rdata(en_rd));
	dags_ram #(.WIDTH(dags_pkg::LINK_W), .DEPTH(dags_pkg::POOL_SIZE)) u_eprev (
		.clk(clk), .we(ep_we), .waddr(ep_wa), .wdata(ep_wd), .raddr(e_ra), .rdata(ep_rd));
	dags_ram #(.WIDTH(dags_pkg::LINK_W), .DEPTH(dags_pkg::POOL_SIZE)) u_ednext (
		.clk(clk), .we(edn_we), .waddr(edn_wa), .wdata(edn_wd), .raddr(e_ra), .rdata(edn_rd));
	dags_ram #(.WIDTH(dags_pkg::LINK_W), .DEPTH(dags_pkg::POOL_SIZE)) u_edprev (
		.clk(clk), .we(edp_we), .waddr(edp_wa), .wdata(edp_wd), .raddr(e_ra), .rdata(edp_rd));

	// Dispatch decisions
	logic cv_room, ce_room, ce_ends_ok, in_more, out_more;
	dags_pkg::vid_t ce_id;
	assign cv_room    = dags_pkg::link_ok(fvh_q) || !vhm_q[dags_pkg::CNT_W-1];
	assign ce_room    = dags_pkg::link_ok(feh_q) || !ehm_q[dags_pkg::CNT_W-1];
	assign ce_ends_ok = vlive_q[tail_q] && vlive_q[head_q];
	assign ce_id      = dags_pkg::link_ok(feh_q) ? feh_q[dags_pkg::VID_W-1:0]
	                                             : ehm_q[dags_pkg::VID_W-1:0];
	assign in_more    = dags_pkg::link_ok(vin_rd) && elive_q[vin_rd[dags_pkg::VID_W-1:0]];
	assign out_more   = dags_pkg::link_ok(vout_rd) && elive_q[vout_rd[dags_pkg::VID_W-1:0]];

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			dags_pkg::S_IDLE:     if (start) state_nx = dags_pkg::S_DISPATCH;
			dags_pkg::S_DISPATCH: begin
				case (cmd_q)
					dags_pkg::CMD_NEW_VERTEX:
						state_nx = cv_room ? dags_pkg::S_CV_WR : dags_pkg::S_DONE;
					dags_pkg::CMD_NEW_EDGE:
						state_nx = (ce_ends_ok && ce_room) ? dags_pkg::S_CE_LINK
						                                   : dags_pkg::S_DONE;
					dags_pkg::CMD_DEL_EDGE:
						state_nx = elive_q[cur_q] ? dags_pkg::S_UN_FETCH : dags_pkg::S_DONE;
					default:
						state_nx = vlive_q[vid_q] ? dags_pkg::S_VD_SCAN : dags_pkg::S_DONE;
				endcase
			end
			dags_pkg::S_CV_WR:    state_nx = dags_pkg::S_DONE;
			dags_pkg::S_CE_LINK:  state_nx = dags_pkg::S_CE_FIX;
			dags_pkg::S_CE_FIX:   state_nx = dags_pkg::S_DONE;
			dags_pkg::S_UN_FETCH: state_nx = dags_pkg::S_UN_HEADS;
			dags_pkg::S_UN_HEADS: state_nx = dags_pkg::S_UN_PATCH;
			dags_pkg::S_UN_PATCH: state_nx = dags_pkg::S_UN_FREE;
			dags_pkg::S_UN_FREE:
				state_nx = (cmd_q == dags_pkg::CMD_DEL_VERTEX) ? dags_pkg::S_VD_SCAN
				                                               : dags_pkg::S_DONE;
			dags_pkg::S_VD_SCAN:
				state_nx = (in_more || out_more) ? dags_pkg::S_UN_FETCH : dags_pkg::S_VD_FIN;
			dags_pkg::S_VD_FIN:   state_nx = dags_pkg::S_DONE;
			dags_pkg::S_DONE:     if (out_free) state_nx = dags_pkg::S_IDLE;
			default:              state_nx = dags_pkg::S_IDLE;
		endcase
	end

	// RAM control and handshake outputs
	always_comb begin
		ready   = (state_q == dags_pkg::S_IDLE);
		done    = (state_q == dags_pkg::S_DONE) && out_free;
		vin_we  = 1'b0; vout_we = 1'b0; et_we = 1'b0; eh_we = 1'b0;
		en_we   = 1'b0; ep_we   = 1'b0; edn_we = 1'b0; edp_we = 1'b0;
		vin_wa  = vid_q; vout_wa = vid_q; e_wa = cur_q;
		en_wa   = cur_q; ep_wa = cur_q; edn_wa = cur_q; edp_wa = cur_q;
		vin_wd  = dags_pkg::NONE_ID; vout_wd = dags_pkg::NONE_ID;
		en_wd   = dags_pkg::NONE_ID; ep_wd = dags_pkg::NONE_ID;
		edn_wd  = dags_pkg::NONE_ID; edp_wd = dags_pkg::NONE_ID;
		et_wd   = tail_q; eh_wd = head_q;
		vin_ra  = vid_q; vout_ra = vid_q; e_ra = cur_q;
		case (state_q)
			dags_pkg::S_DISPATCH: begin
				if (cmd_q == dags_pkg::CMD_NEW_VERTEX) begin
					vout_ra = fvh_q[dags_pkg::VID_W-1:0];
				end else if (cmd_q == dags_pkg::CMD_NEW_EDGE) begin
					vout_ra = tail_q;
					vin_ra  = head_q;
					e_ra    = feh_q[dags_pkg::VID_W-1:0];
				end
			end
			dags_pkg::S_CV_WR: begin
				vin_we = 1'b1; vout_we = 1'b1;
				vin_wa = new_id_q; vout_wa = new_id_q;
			end
			dags_pkg::S_CE_LINK: begin
				et_we = 1'b1; eh_we = 1'b1; en_we = 1'b1; ep_we = 1'b1;
				edn_we = 1'b1; edp_we = 1'b1;
				e_wa = ce_id; en_wa = ce_id; ep_wa = ce_id; edn_wa = ce_id; edp_wa = ce_id;
				en_wd = vout_rd; edn_wd = vin_rd;
			end
			dags_pkg::S_CE_FIX: begin
				ep_we  = dags_pkg::link_ok(oldout_q);
				ep_wa  = oldout_q[dags_pkg::VID_W-1:0];
				ep_wd  = dags_pkg::to_link(new_id_q);
				edp_we = dags_pkg::link_ok(oldin_q);
				edp_wa = oldin_q[dags_pkg::VID_W-1:0];
				edp_wd = dags_pkg::to_link(new_id_q);
				vout_we = 1'b1; vout_wa = tail_q; vout_wd = dags_pkg::to_link(new_id_q);
				vin_we  = 1'b1; vin_wa  = head_q; vin_wd  = dags_pkg::to_link(new_id_q);
			end
			dags_pkg::S_UN_HEADS: begin
				vout_ra = et_rd;
				vin_ra  = eh_rd;
			end
			dags_pkg::S_UN_PATCH: begin
				// Move list heads and splice neighbours around the edge
				vout_we = (vout_rd == dags_pkg::to_link(cur_q));
				vout_wa = t_q; vout_wd = n_q;
				vin_we  = (vin_rd == dags_pkg::to_link(cur_q));
				vin_wa  = h_q; vin_wd = dn_q;
				en_we  = dags_pkg::link_ok(p_q);  en_wa  = p_q[dags_pkg::VID_W-1:0];  en_wd  = n_q;
				ep_we  = dags_pkg::link_ok(n_q);  ep_wa  = n_q[dags_pkg::VID_W-1:0];  ep_wd  = p_q;
				edn_we = dags_pkg::link_ok(dp_q); edn_wa = dp_q[dags_pkg::VID_W-1:0]; edn_wd = dn_q;
				edp_we = dags_pkg::link_ok(dn_q); edp_wa = dn_q[dags_pkg::VID_W-1:0]; edp_wd = dp_q;
			end
			dags_pkg::S_UN_FREE: begin
				en_we = 1'b1; en_wd = feh_q;
				ep_we = 1'b1; edn_we = 1'b1; edp_we = 1'b1;
			end
			dags_pkg::S_VD_FIN: begin
				vout_we = 1'b1; vout_wd = fvh_q;
				vin_we  = 1'b1;
			end
			default: ;
		endcase
	end

	assign result.new_id        = new_id_q;
	assign result.status        = status_q;
	assign result.vertex_count  = vcnt_q;
	assign result.edge_count    = ecnt_q;
	assign result.removed_edges = removed_q;

	// Datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dags_pkg::S_IDLE;
			vlive_q  <= '0;
			elive_q  <= '0;
			fvh_q    <= dags_pkg::NONE_ID;
			feh_q    <= dags_pkg::NONE_ID;
			vhm_q    <= '0;
			ehm_q    <= '0;
			vcnt_q   <= '0;
			ecnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				dags_pkg::S_CV_WR: begin
					if (pop_q) begin
						fvh_q <= vout_rd;
					end else begin
						vhm_q <= vhm_q + 1'b1;
					end
					vlive_q[new_id_q] <= 1'b1;
					vcnt_q <= vcnt_q + 1'b1;
				end
				dags_pkg::S_CE_LINK: begin
					if (dags_pkg::link_ok(feh_q)) begin
						feh_q <= en_rd;
					end else begin
						ehm_q <= ehm_q + 1'b1;
					end
				end
				dags_pkg::S_CE_FIX: begin
					elive_q[new_id_q] <= 1'b1;
					ecnt_q <= ecnt_q + 1'b1;
				end
				dags_pkg::S_UN_FREE: begin
					feh_q <= dags_pkg::to_link(cur_q);
					elive_q[cur_q] <= 1'b0;
					ecnt_q <= ecnt_q - 1'b1;
				end
				dags_pkg::S_VD_FIN: begin
					fvh_q <= dags_pkg::to_link(vid_q);
					vlive_q[vid_q] <= 1'b0;
					vcnt_q <= vcnt_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Command and scratch registers
	always_ff @(posedge clk) begin
		case (state_q)
			dags_pkg::S_IDLE: begin
				if (start) begin
					cmd_q     <= item_in.command;
					tail_q    <= item_in.tail_vertex;
					head_q    <= item_in.head_vertex;
					vid_q     <= item_in.vertex_id;
					cur_q     <= item_in.edge_id;
					new_id_q  <= '0;
					status_q  <= dags_pkg::STAT_OK;
					removed_q <= '0;
				end
			end
			dags_pkg::S_DISPATCH: begin
				case (cmd_q)
					dags_pkg::CMD_NEW_VERTEX: begin
						pop_q <= dags_pkg::link_ok(fvh_q);
						if (!cv_room) begin
							status_q <= dags_pkg::STAT_FULL;
						end else if (dags_pkg::link_ok(fvh_q)) begin
							new_id_q <= fvh_q[dags_pkg::VID_W-1:0];
						end else begin
							new_id_q <= vhm_q[dags_pkg::VID_W-1:0];
						end
					end
					dags_pkg::CMD_NEW_EDGE: begin
						if (!ce_ends_ok) begin
							status_q <= dags_pkg::STAT_BAD;
						end else if (!ce_room) begin
							status_q <= dags_pkg::STAT_FULL;
						end
					end
					dags_pkg::CMD_DEL_EDGE:
						if (!elive_q[cur_q]) status_q <= dags_pkg::STAT_BAD;
					default:
						if (!vlive_q[vid_q]) status_q <= dags_pkg::STAT_BAD;
				endcase
			end
			dags_pkg::S_CE_LINK: begin
				new_id_q <= ce_id;
				oldout_q <= vout_rd;
				oldin_q  <= vin_rd;
			end
			dags_pkg::S_UN_HEADS: begin
				t_q  <= et_rd;
				h_q  <= eh_rd;
				n_q  <= en_rd;
				p_q  <= ep_rd;
				dn_q <= edn_rd;
				dp_q <= edp_rd;
			end
			dags_pkg::S_UN_FREE:
				removed_q <= removed_q + 1'b1;
			dags_pkg::S_VD_SCAN: begin
				if (in_more) begin
					cur_q <= vin_rd[dags_pkg::VID_W-1:0];
				end else if (out_more) begin
					cur_q <= vout_rd[dags_pkg::VID_W-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule

// File: src/digraph_adjacency_store_core.sv
// Digraph with POOL_SIZE vertex and POOL_SIZE edge slots, kept as doubly linked
// incoming and outgoing edge lists in block RAM, with LIFO free lists for reuse.
// One command is processed at a time and gives one result item. An erroneous
// command goes from dispatch straight to the done state; delete vertex unlinks
// each of its edges in turn. s_tready rises again in the same cycle as m_tvalid.
// A result left waiting in the output register holds the sequencer in its last
// state until the register is taken. Commands run as the sequencer's chain of
// dependent reads and writes on the link RAMs, each with one write and one
// registered read port. Never-used slots are handed out in ascending order.
module digraph_adjacency_store_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[1:0], tail_vertex[8:2], head_vertex[15:9], edge_id[22:16],
	// vertex_id[29:23], zero [31:30]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// new_id[6:0], status[8:7], vertex_count[16:9], edge_count[24:17],
	// removed_edges[32:25], zero [39:33]
	output logic [39:0] m_tdata
);

	dags_pkg::item_t   item;
	dags_pkg::result_t res;
	logic seq_ready, seq_done, out_free;
	logic              m_tvalid_q;
	dags_pkg::result_t res_q;

	// Unpack command item
	assign item.command     = dags_pkg::cmd_t'(s_tdata[1:0]);
	assign item.tail_vertex = s_tdata[8:2];
	assign item.head_vertex = s_tdata[15:9];
	assign item.edge_id     = s_tdata[22:16];
	assign item.vertex_id   = s_tdata[29:23];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = seq_ready;

	dags_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (s_tvalid && seq_ready),
		.item_in (item),
		.out_free(out_free),
		.ready   (seq_ready),
		.done    (seq_done),
		.result  (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (seq_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, res_q.removed_edges, res_q.edge_count, res_q.vertex_count,
	                   res_q.status, res_q.new_id};

endmodule

// File: src/dags_checker.sv
module dags_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One command at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted while busy");

	// Failed commands report no id and no removals
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[8:7] != 2'd0) |-> (m_tdata[6:0] == 7'd0)
			&& (m_tdata[32:25] == 8'd0))
		else $error("error result carries data");

	// Counts stay within the pools
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:9] <= 8'd128) && (m_tdata[24:17] <= 8'd128))
		else $error("count beyond pool size");

endmodule

bind digraph_adjacency_store_core dags_checker u_dags_checker (.*);
